/* rtl/esd_pkg.sv */
// shared constants and helper functions for the epoch seconds to calendar date block
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

  // seconds in one day and the calendar origin
  localparam int unsigned SecsPerDay   = 86400;
  localparam int unsigned EpochYear    = 1970;
  localparam int unsigned DaysPerYear  = 365;

  // 86400 is 675 times 128: a shift drops the power of two, a reciprocal handles the rest
  localparam int unsigned SecsDayShift = 7;
  localparam int unsigned SecsDayOdd   = SecsPerDay >> SecsDayShift;

  // origin year 1970 taken modulo 100 and 400, origin weekday Thursday (Monday is 0)
  localparam logic [6:0] EPOCH_MOD100  = 7'd70;
  localparam logic [8:0] EPOCH_MOD400  = 9'd370;
  localparam logic [2:0] EPOCH_WEEKDAY = 3'd3;

  // last values of the modulo counters before they wrap
  localparam logic [6:0] MOD100_LAST   = 7'd99;
  localparam logic [8:0] MOD400_LAST   = 9'd399;

  // month index of December, counted from zero
  localparam logic [3:0] LAST_MONTH    = 4'd11;

  // length of a month, month index counted from zero
  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] mon);
    logic [4:0] len;
    len = 5'd31;
    case (mon) inside
      4'd1:                   len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

  // five bit value reduced modulo seven
  function automatic logic [2:0] mod7_5(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (r >= 5'd28) r = r - 5'd28;
    if (r >= 5'd14) r = r - 5'd14;
    if (r >= 5'd7)  r = r - 5'd7;
    return r[2:0];
  endfunction

  // sum of two weekday offsets, each below seven, reduced modulo seven
  function automatic logic [2:0] wd_add(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd7) s = s - 4'd7;
    return s[2:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/epoch_seconds_to_calendar_date_top.sv */
// Converts a count of seconds since 1970-01-01 to a Gregorian date with weekday information.
// One beat carries a second count; one result beat follows it with year, month, day of month,
// the month length and the weekdays (Monday is 0) of the date and of the month's first day.
// Time of day is dropped and only the low SECONDS_BITS bits of the input are used. The block
// works on one beat at a time and holds in_stall_o high while busy: it accepts the beat,
// divides by 86400 (a shift and a reciprocal multiply), strips whole years past 1970 and
// then whole months through the shared subtractor, and loads the result register. The load
// waits while an earlier result is still stalled. A finished result waits in its own register,
// so a new beat can be taken while the previous result is still stalled at the output.
`timescale 1ns / 1ps
`default_nettype none

module epoch_seconds_to_calendar_date_top #(
  parameter int unsigned SECONDS_BITS = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output      logic                    in_stall_o,
  input  wire logic [SECONDS_BITS-1:0] epoch_seconds_i,
  output      logic                    out_valid_o,
  input  wire logic                    out_stall_i,
  output      logic [11:0]             year_o,
  output      logic [3:0]              month_o,
  output      logic [4:0]              day_o,
  output      logic [2:0]              weekday_o,
  output      logic [2:0]              first_weekday_o,
  output      logic [4:0]              month_length_o
);
  import esd_pkg::*;

  // widths that follow from the second count
  localparam int unsigned DAY_BITS  = SECONDS_BITS - 16;
  localparam int unsigned YEAR_BITS = $clog2(EpochYear + (2**DAY_BITS) / DaysPerYear + 2);

  // reciprocal of 675 for the seconds shifted down by 128
  localparam int unsigned SHR_BITS    = SECONDS_BITS - SecsDayShift;
  localparam int unsigned RECIP_BITS  = SHR_BITS + 1;
  localparam int unsigned RECIP_SHIFT = SHR_BITS + $clog2(SecsDayOdd);
  localparam longint unsigned RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + SecsDayOdd - 1) / SecsDayOdd;
  localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_FULL);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_YEAR  = 3'd2;
  localparam logic [2:0] ST_MONTH = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [SECONDS_BITS-1:0] rem_q, rem_d;
  logic [DAY_BITS-1:0]     days_q, days_d;
  logic [YEAR_BITS-1:0]    year_q, year_d;
  logic [6:0]              c100_q, c100_d;
  logic [8:0]              c400_q, c400_d;
  logic [2:0]              wd_q, wd_d;
  logic [3:0]              mon_q, mon_d;

  logic                    out_valid_q, out_valid_d;
  logic [11:0]             year_out_q;
  logic [3:0]              month_out_q;
  logic [4:0]              day_out_q;
  logic [2:0]              wd_out_q;
  logic [2:0]              fwd_out_q;
  logic [4:0]              len_out_q;

  logic                    leap;
  logic [8:0]              ylen;
  logic [4:0]              mlen;
  logic                    load_out;
  logic [SHR_BITS-1:0]     sec_shr;
  logic [SHR_BITS+RECIP_BITS-1:0] prod;

  // leap year from the running modulo counters
  assign leap = (c400_q == '0) || ((c100_q != '0) && (year_q[1:0] == 2'd0));
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_days(leap, mon_q);

  // whole days: drop the factor 128, then multiply by the reciprocal of 675
  assign sec_shr = rem_q[SECONDS_BITS-1:SecsDayShift];
  assign prod    = {{RECIP_BITS{1'b0}}, sec_shr} * {{SHR_BITS{1'b0}}, RECIP};

  assign load_out = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  // sequencer and shared subtract datapath
  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    days_d  = days_q;
    year_d  = year_q;
    c100_d  = c100_q;
    c400_d  = c400_q;
    wd_d    = wd_q;
    mon_d   = mon_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DIV;
          rem_d   = epoch_seconds_i;
          days_d  = '0;
          year_d  = YEAR_BITS'(EpochYear);
          c100_d  = EPOCH_MOD100;
          c400_d  = EPOCH_MOD400;
          wd_d    = EPOCH_WEEKDAY;
          mon_d   = '0;
        end
      end
      ST_DIV: begin
        // day count from the top bits of the reciprocal product
        days_d  = prod[RECIP_SHIFT +: DAY_BITS];
        state_d = ST_YEAR;
      end
      ST_YEAR: begin
        // strip one whole year a cycle
        if (days_q < {{(DAY_BITS-9){1'b0}}, ylen}) begin
          state_d = ST_MONTH;
        end else begin
          days_d = days_q - {{(DAY_BITS-9){1'b0}}, ylen};
          year_d = year_q + 1'b1;
          c100_d = (c100_q == MOD100_LAST) ? '0 : c100_q + 1'b1;
          c400_d = (c400_q == MOD400_LAST) ? '0 : c400_q + 1'b1;
          wd_d   = wd_add(wd_q, {2'b0, 1'b1} + {2'b0, leap});
        end
      end
      ST_MONTH: begin
        // strip one whole month a cycle, weekday tracks the first of the month
        if ((mon_q < LAST_MONTH) && (days_q >= {{(DAY_BITS-5){1'b0}}, mlen})) begin
          days_d = days_q - {{(DAY_BITS-5){1'b0}}, mlen};
          mon_d  = mon_q + 1'b1;
          wd_d   = wd_add(wd_q, {1'b0, 2'(mlen - 5'd28)});
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    days_q <= days_d;
    year_q <= year_d;
    c100_q <= c100_d;
    c400_q <= c400_d;
    wd_q   <= wd_d;
    mon_q  <= mon_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      year_out_q  <= year_q[11:0];
      month_out_q <= mon_q + 1'b1;
      day_out_q   <= days_q[4:0] + 1'b1;
      wd_out_q    <= wd_add(wd_q, mod7_5(days_q[4:0]));
      fwd_out_q   <= wd_q;
      len_out_q   <= mlen;
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign year_o          = year_out_q;
  assign month_o         = month_out_q;
  assign day_o           = day_out_q;
  assign weekday_o       = wd_out_q;
  assign first_weekday_o = fwd_out_q;
  assign month_length_o  = len_out_q;

`ifndef SYNTHESIS
  // an accepted beat always starts the divide
  a_accept_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && !in_stall_o |=> state_q == ST_DIV)
    else $error("accepted beat did not start the divide");

  // month walk never passes December
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      state_q == ST_MONTH |-> mon_q <= LAST_MONTH)
    else $error("month index out of range");

  // remaining days fit the month once the walk ends
  a_fin_days: assert property (@(posedge clk_i) disable iff (!rst_ni)
      state_q == ST_FIN |-> days_q < {{(DAY_BITS-5){1'b0}}, mlen})
    else $error("day count exceeds month length");

  // delivered dates are consistent
  a_out_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> month_o >= 4'd1 && month_o <= 4'd12 && day_o >= 5'd1 &&
                      day_o <= month_length_o && weekday_o <= 3'd6 &&
                      first_weekday_o <= 3'd6)
    else $error("result date out of range");
`endif

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// testbench for the epoch seconds to calendar date block: prediction, stimulus and checks
`timescale 1ns / 1ps

module tb_top;

  // one calendar result as the block reports it
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [2:0]  first_weekday;
    logic [4:0]  month_length;
  } calendar_date_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [31:0] epoch_seconds_i = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [11:0] year_o;
  logic [3:0]  month_o;
  logic [4:0]  day_o;
  logic [2:0]  weekday_o;
  logic [2:0]  first_weekday_o;
  logic [4:0]  month_length_o;

  // dates still owed by the block, oldest first
  calendar_date_t pending_dates[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_hold    = 0;
  int unsigned dates_checked = 0;
  int unsigned mismatches    = 0;
  int unsigned unexpected    = 0;

  epoch_seconds_to_calendar_date_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .epoch_seconds_i (epoch_seconds_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .year_o          (year_o),
    .month_o         (month_o),
    .day_o           (day_o),
    .weekday_o       (weekday_o),
    .first_weekday_o (first_weekday_o),
    .month_length_o  (month_length_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // gregorian leap rule
  function automatic bit leap_year(input int unsigned y);
    if (y % 400 == 0) return 1'b1;
    if (y % 100 == 0) return 1'b0;
    return (y % 4 == 0);
  endfunction

  // days in month mon (1 is January)
  function automatic int unsigned month_span(input bit leap, input int unsigned mon);
    case (mon)
      2:           return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // zeller congruence, result with monday as 0
  function automatic logic [2:0] zeller_day(input int unsigned q, input int unsigned m,
                                            input int unsigned y);
    int unsigned k;
    int unsigned j;
    int unsigned h;
    if (m < 3) begin
      m = m + 12;
      y = y - 1;
    end
    k = y % 100;
    j = y / 100;
    h = (q + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
    return 3'((h + 5) % 7);
  endfunction

  // full conversion of one second count
  function automatic calendar_date_t calendar_of(input logic [31:0] secs);
    calendar_date_t r;
    int unsigned    days;
    int unsigned    y;
    int unsigned    mon;
    bit             leap;
    days = secs / esd_pkg::SecsPerDay;
    y    = esd_pkg::EpochYear;
    leap = leap_year(y);
    while (days >= (leap ? 366 : 365)) begin
      days = days - (leap ? 366 : 365);
      y    = y + 1;
      leap = leap_year(y);
    end
    mon = 1;
    while (mon < 12 && days >= month_span(leap, mon)) begin
      days = days - month_span(leap, mon);
      mon  = mon + 1;
    end
    r.year          = 12'(y);
    r.month         = 4'(mon);
    r.day           = 5'(days + 1);
    r.weekday       = zeller_day(days + 1, mon, y);
    r.first_weekday = zeller_day(1, mon, y);
    r.month_length  = 5'(month_span(leap, mon));
    return r;
  endfunction

  // receiver: long hold-off when asked, else random stalls
  always @(posedge clk_i) begin
    if (stall_hold > 0) begin
      out_stall_i <= 1'b1;
      stall_hold = stall_hold - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // check each accepted result beat against the oldest prediction
  always @(posedge clk_i) begin
    calendar_date_t got;
    calendar_date_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{year_o, month_o, day_o, weekday_o, first_weekday_o, month_length_o};
      if (pending_dates.size() == 0) begin
        unexpected = unexpected + 1;
        $display("unexpected result beat: %0d-%0d-%0d", got.year, got.month, got.day);
      end else begin
        want = pending_dates.pop_front();
        dates_checked = dates_checked + 1;
        if (got !== want) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("mismatch: expected y=%0d m=%0d d=%0d wd=%0d fwd=%0d len=%0d",
                     want.year, want.month, want.day, want.weekday,
                     want.first_weekday, want.month_length);
            $display("          actual   y=%0d m=%0d d=%0d wd=%0d fwd=%0d len=%0d",
                     got.year, got.month, got.day, got.weekday,
                     got.first_weekday, got.month_length);
          end
        end
      end
    end
  end

  // offer one beat, idling first at random, and record its date once accepted
  task automatic send_seconds(input logic [31:0] secs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    epoch_seconds_i <= secs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_dates.push_back(calendar_of(secs));
  endtask

  // stop offering and let every owed result come back
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
  endtask

  // extremes, leap and century edges, every month of a leap year
  task automatic test_directed;
    int unsigned month_start[12] = '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335};
    send_seconds(32'd0);
    send_seconds(32'd86399);
    send_seconds(32'd86400);
    send_seconds(32'd31449600);   // last day of 1970
    send_seconds(32'd31536000);   // first day of 1971
    send_seconds(32'd946684799);  // end of 1999
    send_seconds(32'd951782400);  // leap day in a 400-year leap year
    send_seconds(32'd951868800);
    send_seconds(32'd4107456000); // end of february in a century non-leap year
    send_seconds(32'd4107542400);
    send_seconds(32'h7FFF_FFFF);
    send_seconds(32'hFFFF_FFFF);
    for (int i = 0; i < 12; i++) send_seconds((32'd19723 + month_start[i]) * 32'd86400);
    drain();
  endtask

  // uniform second counts over the whole range
  task automatic test_uniform(input int unsigned count);
    for (int i = 0; i < count; i++) send_seconds($urandom);
    drain();
  endtask

  // counts at the start, the end or anywhere within a random day, mixed with uniform ones
  task automatic test_day_edges(input int unsigned count);
    logic [31:0] secs;
    for (int i = 0; i < count; i++) begin
      secs = $urandom_range(49709) * 32'd86400;
      case ($urandom_range(3))
        0:       secs = secs;
        1:       secs = secs + 32'd86399;
        2:       secs = secs + $urandom_range(86399);
        default: secs = $urandom;
      endcase
      send_seconds(secs);
    end
    drain();
  endtask

  // hold the output off for a long stretch while beats keep coming
  task automatic test_output_holdoff;
    @(negedge clk_i);
    stall_hold = 600;
    @(posedge clk_i);
    for (int i = 0; i < 12; i++) send_seconds($urandom_range(63072000));
    while (stall_hold != 0) @(posedge clk_i);
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 8;
    recv_idle_pct = 59;
    test_directed();
    test_uniform(300);

    send_idle_pct = 59;
    recv_idle_pct = 8;
    test_day_edges(300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_uniform(150);
    test_output_holdoff();

    repeat (200) @(posedge clk_i);
    $display("checked %0d dates: range extremes, leap and century edges, all months,",
             dates_checked);
    $display("uniform and day-edge random counts, and a long output hold-off");
    if (mismatches == 0 && unexpected == 0 && pending_dates.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
